FILE: rtl/bot_pkg.sv
// Shared types, direction tables and vertex arithmetic for the bounding octagon tracker.
package bot_pkg;

    localparam int COORD_BITS  = 16;
    localparam int MIN_W       = COORD_BITS + 2;
    localparam int VERT_W      = COORD_BITS + 2;
    localparam int NUM_DIR     = 8;
    localparam int DIR_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [MIN_W-1:0]      min_t;
    typedef logic signed [MIN_W:0]        wide_t;
    typedef logic signed [VERT_W-1:0]     vert_t;
    typedef logic signed [1:0]            coef_t;
    typedef logic [DIR_IDX_W-1:0]         dir_idx_t;
    typedef logic [NUM_DIR-1:0]           dir_mask_t;
    typedef min_t [NUM_DIR-1:0]           min_set_t;

    typedef struct packed {
        vert_t x;
        vert_t y;
    } vertex_t;

    // Direction vectors, one component per table.
    localparam coef_t DIR_X [NUM_DIR] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                          2'sd1,  2'sd1,  2'sd1,  2'sd0};
    localparam coef_t DIR_Y [NUM_DIR] = '{-2'sd1, 2'sd0,  2'sd1,  2'sd1,
                                          2'sd1,  2'sd0, -2'sd1, -2'sd1};

    // Multiplication by a coefficient of -1, 0 or +1.
    function automatic min_t scale_min(min_t v, coef_t c);
        if (c == 2'sd1) begin
            return v;
        end else if (c == -2'sd1) begin
            return -v;
        end
        return '0;
    endfunction

    function automatic wide_t scale_wide(wide_t v, coef_t c);
        if (c == 2'sd1) begin
            return v;
        end else if (c == -2'sd1) begin
            return -v;
        end
        return '0;
    endfunction

    // Intersection of the support lines of pair p: lines -p mod 8 and 7-p.
    // The determinant is always +1 or -1, so only its sign matters.
    function automatic vertex_t pair_vertex(min_set_t m, dir_idx_t p);
        dir_idx_t a;
        dir_idx_t b;
        coef_t    a1;
        coef_t    b1;
        coef_t    a2;
        coef_t    b2;
        wide_t    m1;
        wide_t    m2;
        wide_t    tx;
        wide_t    ty;
        logic     neg;
        vertex_t  r;
        a   = dir_idx_t'(0) - p;
        b   = dir_idx_t'(NUM_DIR - 1) - p;
        a1  = DIR_X[a];
        b1  = DIR_Y[a];
        a2  = DIR_X[b];
        b2  = DIR_Y[b];
        m1  = wide_t'(m[a]);
        m2  = wide_t'(m[b]);
        tx  = scale_wide(m1, b2) - scale_wide(m2, b1);
        ty  = scale_wide(m2, a1) - scale_wide(m1, a2);
        neg = ((int'(a1) * int'(b2)) - (int'(a2) * int'(b1))) < 0;
        if (neg) begin
            tx = -tx;
            ty = -ty;
        end
        r.x = tx[VERT_W-1:0];
        r.y = ty[VERT_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/bounding_octagon_tracker_unit.sv
// Top level of the bounding octagon tracker: front, snapshot queue and vertex back end.
// Throughput: one point item per cycle while the snapshot queue has room; vertices leave
// at one item per cycle while the receiver is ready, at most eight per set.
// A set's first vertex passes the queue, the vertex registers and the output register.
// Reset (aresetn, synchronous, active low) empties the queue, clears the output and
// marks the next point as the start of a new set.
module bounding_octagon_tracker_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bot_pkg::coord_t s_point_x,
    input  bot_pkg::coord_t s_point_y,
    input  logic            s_last_point,
    output logic            m_valid,
    input  logic            m_ready,
    output bot_pkg::vert_t  m_vertex_x,
    output bot_pkg::vert_t  m_vertex_y,
    output logic            m_last_vertex
);
    import bot_pkg::*;

    // The front updates the eight minima on every accepted item. When an item closes
    // a set, the minima including that item are pushed into the queue as a snapshot,
    // and the front is at once free to start the next set.
    logic     push_valid;
    min_set_t push_minima;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    min_set_t q_head;

    bot_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .s_last_point (s_last_point),
        .q_full       (q_full),
        .push_valid   (push_valid),
        .push_minima  (push_minima)
    );

    // The queue holds finished snapshots, so a slow result consumer stalls the
    // front only once the queue has filled.
    bot_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_minima),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    // The back end intersects adjacent support lines, drops a vertex equal to its
    // predecessor and sends the rest through a registered output, marking the final one.
    bot_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .head          (q_head),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex_x    (m_vertex_x),
        .m_vertex_y    (m_vertex_y),
        .m_last_vertex (m_last_vertex)
    );

endmodule

FILE: rtl/bot_front.sv
// Front part: accepts points and keeps the eight running directional minima.
module bot_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bot_pkg::coord_t   s_point_x,
    input  bot_pkg::coord_t   s_point_y,
    input  logic              s_last_point,
    input  logic              q_full,
    output logic              push_valid,
    output bot_pkg::min_set_t push_minima
);
    import bot_pkg::*;

    min_set_t minima_reg;
    min_set_t minima_next;
    logic     set_empty_reg;
    logic     accept;
    min_t     px;
    min_t     py;
    min_t     dot [NUM_DIR];

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign px      = min_t'(s_point_x);
    assign py      = min_t'(s_point_y);

    always_comb begin
        for (int i = 0; i < NUM_DIR; i++) begin
            dot[i] = scale_min(px, DIR_X[i]) + scale_min(py, DIR_Y[i]);
            if (set_empty_reg || (dot[i] < minima_reg[i])) begin
                minima_next[i] = dot[i];
            end else begin
                minima_next[i] = minima_reg[i];
            end
        end
    end

    // The snapshot handed on includes the closing point's own update.
    assign push_valid  = accept && s_last_point;
    assign push_minima = minima_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minima_reg    <= '0;
            set_empty_reg <= 1'b1;
        end else if (accept) begin
            minima_reg    <= minima_next;
            set_empty_reg <= s_last_point;
        end
    end

endmodule

FILE: rtl/bot_queue.sv
// Short queue of minima snapshots between the front and back parts.
module bot_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bot_pkg::min_set_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output bot_pkg::min_set_t head
);
    import bot_pkg::*;

    min_set_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("Snapshot pushed into a full queue.");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("Snapshot popped from an empty queue.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue fill count beyond its depth.");

endmodule

FILE: rtl/bot_back.sv
// Back part: turns a minima snapshot into octagon vertices and sends them out.
module bot_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  bot_pkg::min_set_t head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output bot_pkg::vert_t    m_vertex_x,
    output bot_pkg::vert_t    m_vertex_y,
    output logic              m_last_vertex
);
    import bot_pkg::*;

    vertex_t   vert_reg [NUM_DIR];
    vertex_t   cand [NUM_DIR];
    dir_mask_t keep;
    dir_mask_t mask_reg;
    dir_mask_t mask_next;
    dir_mask_t mask_rest;
    dir_idx_t  sel;
    logic      out_free;
    logic      emit;
    logic      load;
    logic      m_valid_reg;
    logic      m_valid_next;
    vert_t     m_vertex_x_reg;
    vert_t     m_vertex_y_reg;
    logic      m_last_vertex_reg;

    // Vertices of the head snapshot; a vertex equal to its predecessor is dropped.
    always_comb begin
        for (int i = 0; i < NUM_DIR; i++) begin
            cand[i] = pair_vertex(head, dir_idx_t'(i));
        end
        keep[0] = 1'b1;
        for (int i = 1; i < NUM_DIR; i++) begin
            keep[i] = (cand[i] != cand[i-1]);
        end
    end

    always_comb begin
        sel = '0;
        for (int i = NUM_DIR - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = dir_idx_t'(i);
            end
        end
    end

    assign mask_rest    = mask_reg & (mask_reg - dir_mask_t'(1));
    assign out_free     = !m_valid_reg || m_ready;
    assign emit         = (mask_reg != '0) && out_free;
    assign load         = !q_empty && ((mask_reg == '0) || (emit && (mask_rest == '0)));
    assign pop          = load;
    assign mask_next    = load ? keep : (emit ? mask_rest : mask_reg);
    assign m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_DIR; i++) begin
                vert_reg[i] <= cand[i];
            end
        end
        if (emit) begin
            m_vertex_x_reg    <= vert_reg[sel].x;
            m_vertex_y_reg    <= vert_reg[sel].y;
            m_last_vertex_reg <= (mask_rest == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_vertex_x    = m_vertex_x_reg;
    assign m_vertex_y    = m_vertex_y_reg;
    assign m_last_vertex = m_last_vertex_reg;

    a_first_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> mask_reg[0])
        else $error("Loaded vertex set does not keep its first vertex.");

    a_emit_needs_space: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid_reg)
        else $error("Emitted vertex did not reach the output register.");

    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_vertex_x_reg)
            && $stable(m_vertex_y_reg) && $stable(m_last_vertex_reg)))
        else $error("Output item changed while waiting for acceptance.");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the bounding octagon tracker unit.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bot_pkg::*;

    // The run is ended as a failure if it is still going after this many cycles.
    // The worst case is roughly 460 items, each closing a set of eight vertices,
    // with every vertex waiting out a long receiver stall. That is well under this figure.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles allowed after the last expected vertex, to catch any stray output items.
    localparam int TAIL_CYCLES = 16;

    // Direction vectors of the eight support lines, x and y components.
    localparam int DIR_DX [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
    localparam int DIR_DY [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};

    typedef struct {
        vert_t x;
        vert_t y;
        logic  last;
    } vertex_item_t;

    logic   aclk          = 1'b0;
    logic   aresetn       = 1'b0;
    logic   s_valid       = 1'b0;
    logic   s_ready;
    coord_t s_point_x     = '0;
    coord_t s_point_y     = '0;
    logic   s_last_point  = 1'b0;
    logic   m_valid;
    logic   m_ready       = 1'b0;
    vert_t  m_vertex_x;
    vert_t  m_vertex_y;
    logic   m_last_vertex;

    // Idling controls: the chance, in percent, that the sender holds back an item
    // at each try, and that the receiver drops ready at each rising edge.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int fail_count = 0;
    int cycle_count = 0;

    // Predicted vertices still to be delivered, oldest first.
    vertex_item_t pending_vertices [$];

    // Our own copy of the tracker state: running minima of the dot products and the
    // flag that says the next point opens a new set.
    int minima [8];
    bit fresh_set;

    bounding_octagon_tracker_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_last_point  (s_last_point),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_vertex_x    (m_vertex_x),
        .m_vertex_y    (m_vertex_y),
        .m_last_vertex (m_last_vertex)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost vertex ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver decides its ready for the coming cycle at each rising edge.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Outputs and ready are only ever changed at rising edges, so at the falling
    // edge they are settled and show exactly what the next rising edge will accept.
    always @(negedge aclk) begin
        vertex_item_t exp_v;
        if (aresetn && m_valid && m_ready) begin
            if (pending_vertices.size() == 0) begin
                $error("vertex item (%0d, %0d) delivered with nothing expected",
                       m_vertex_x, m_vertex_y);
                fail_count++;
            end else begin
                exp_v = pending_vertices.pop_front();
                if (m_vertex_x !== exp_v.x) begin
                    $error("vertex_x: expected %0d, actual %0d", exp_v.x, m_vertex_x);
                    fail_count++;
                end
                if (m_vertex_y !== exp_v.y) begin
                    $error("vertex_y: expected %0d, actual %0d", exp_v.y, m_vertex_y);
                    fail_count++;
                end
                if (m_last_vertex !== exp_v.last) begin
                    $error("last_vertex: expected %0b, actual %0b",
                           exp_v.last, m_last_vertex);
                    fail_count++;
                end
            end
        end
    end

    // Updates the running minima with one accepted point and, when it closes the set,
    // queues the octagon vertices that the block should emit for it.
    function automatic void predict_octagon(coord_t px, coord_t py, logic last);
        int           dot;
        int           a;
        int           b;
        int           det;
        int           vx;
        int           vy;
        int           prev_x;
        int           prev_y;
        vertex_item_t v;
        vertex_item_t found [$];
        for (int i = 0; i < 8; i++) begin
            dot = DIR_DX[i] * int'(px) + DIR_DY[i] * int'(py);
            // Only a strictly smaller value replaces a minimum within a set.
            if (fresh_set || dot < minima[i]) begin
                minima[i] = dot;
            end
        end
        fresh_set = 1'b0;
        if (!last) begin
            return;
        end
        // Walk the pairs of neighbouring support lines (0,7), (7,6) down to (1,0).
        for (int i = 0; i < 8; i++) begin
            a   = (8 - i) % 8;
            b   = 7 - i;
            det = DIR_DX[a] * DIR_DY[b] - DIR_DX[b] * DIR_DY[a];
            vx  = (minima[a] * DIR_DY[b] - minima[b] * DIR_DY[a]) * det;
            vy  = (DIR_DX[a] * minima[b] - DIR_DX[b] * minima[a]) * det;
            // A vertex that repeats its predecessor is dropped; the first and the
            // last are never compared with each other.
            if (i == 0 || vx != prev_x || vy != prev_y) begin
                v.x    = vert_t'(vx);
                v.y    = vert_t'(vy);
                v.last = 1'b0;
                found  = {found, v};
            end
            prev_x = vx;
            prev_y = vy;
        end
        found[found.size() - 1].last = 1'b1;
        foreach (found[k]) begin
            pending_vertices = {pending_vertices, found[k]};
        end
        fresh_set = 1'b1;
    endfunction

    // Offers one point item and returns at the rising edge that accepts it. The task
    // is entered and left in the time step of a rising edge.
    task automatic send_point(input int x, input int y, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_point_x    <= coord_t'(x);
        s_point_y    <= coord_t'(y);
        s_last_point <= last;
        @(negedge aclk);
        while (!s_ready) begin
            @(negedge aclk);
        end
        predict_octagon(coord_t'(x), coord_t'(y), last);
        @(posedge aclk);
    endtask

    // Holds the input side idle until every predicted vertex has been delivered.
    task automatic wait_for_vertices();
        s_valid <= 1'b0;
        while (pending_vertices.size() != 0) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    // Sets of a single point: the point itself comes back as the one marked vertex.
    task automatic test_single_point_sets();
        send_point(0, 0, 1'b1);
        send_point(-32768, -32768, 1'b1);
        send_point(32767, 32767, 1'b1);
        send_point(32767, -32768, 1'b1);
        send_point(-32768, 32767, 1'b1);
    endtask

    // Opposite corners of the coordinate range give the longest diagonal segments and
    // push the diagonal minima to the edges of their range.
    task automatic test_extreme_corners();
        send_point(-32768, -32768, 1'b0);
        send_point(32767, 32767, 1'b1);
        send_point(32767, -32768, 1'b0);
        send_point(-32768, 32767, 1'b1);
    endtask

    // Eight points around the origin that give eight distinct vertices.
    task automatic test_full_octagon();
        send_point(3, 10, 1'b0);
        send_point(10, 3, 1'b0);
        send_point(10, -3, 1'b0);
        send_point(3, -10, 1'b0);
        send_point(-3, -10, 1'b0);
        send_point(-10, -3, 1'b0);
        send_point(-10, 3, 1'b0);
        send_point(-3, 10, 1'b1);
    endtask

    // Equal dot products must leave the minima alone, and points on one line
    // collapse the octagon to a segment; a vertex equal to its predecessor is dropped.
    task automatic test_ties_and_degenerate_sets();
        send_point(-5, 7, 1'b0);
        send_point(-5, 7, 1'b0);
        send_point(-5, 7, 1'b1);
        send_point(-20, 4, 1'b0);
        send_point(0, 4, 1'b0);
        send_point(20, 4, 1'b1);
    endtask

    function automatic int rand_coord(int base);
        int r;
        int v;
        r = $urandom_range(9);
        if (r < 3) begin
            return int'(coord_t'($urandom));
        end else if (r == 3) begin
            return $urandom_range(1) ? 32767 : -32768;
        end
        v = base + int'($urandom_range(40)) - 20;
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return v;
    endfunction

    // Random sets of random size, mostly short, clustered or spread across the range.
    task automatic test_random_sets(input int n_items, input int idle_pct, input int stall_pct);
        int sent;
        int set_size;
        int base_x;
        int base_y;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            set_size = ($urandom_range(9) == 0) ? $urandom_range(16, 1) : $urandom_range(6, 1);
            base_x   = int'(coord_t'($urandom));
            base_y   = int'(coord_t'($urandom));
            for (int k = 0; k < set_size; k++) begin
                send_point(rand_coord(base_x), rand_coord(base_y), k == set_size - 1);
                sent++;
            end
        end
    endtask

    // A burst of sets, then a pause on the input side until the output has caught up.
    task automatic test_pause_until_drained();
        test_random_sets(20, 0, 50);
        wait_for_vertices();
        test_random_sets(12, 0, 0);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) begin
            minima[i] = 0;
        end
        fresh_set = 1'b1;

        // Reset is held from the start and then released for good.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_single_point_sets();
        test_extreme_corners();
        test_full_octagon();
        test_ties_and_degenerate_sets();

        test_random_sets(100, 0, 0);
        test_random_sets(100, 80, 0);
        test_pause_until_drained();
        test_random_sets(100, 0, 80);
        test_random_sets(100, 35, 35);

        // All items are in: wait for the last vertices, then watch for strays.
        wait_for_vertices();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_vertices.size() != 0) begin
            $error("%0d expected vertex items never delivered", pending_vertices.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bot_pkg.sv
rtl/bot_front.sv
rtl/bot_queue.sv
rtl/bot_back.sv
rtl/bounding_octagon_tracker_unit.sv
verif/tb_top.sv
